>>> hdl/ztr_pkg.sv
package ztr_pkg;

    // Field widths of one control sample and of one result.
    localparam int STICK_W = 8;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 10;
    localparam int STEER_W = 10;
    localparam int LEVEL_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEER_CENTER  = 2'd0,
        REG_MAX_LEVEL     = 2'd1,
        REG_RESTART_LEVEL = 2'd2
    } t_cfg_idx;

    // Reset values of the registers and the state.
    localparam logic [STEER_W-1:0] STEER_CENTER_RST  = 10'd860;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST     = 8'd160;
    localparam logic [LEVEL_W-1:0] RESTART_LEVEL_RST = 8'd10;
    localparam logic [LEVEL_W-1:0] DRIVE_LEVEL_RST   = 8'd10;

    // A stick reading at or above this value means the stick is released.
    localparam logic [STICK_W-1:0] STICK_RELEASE = 8'd90;

    // Steering zone windows and their speed limits (speed has 4 fraction bits).
    localparam logic [STEER_W-1:0] ZONE_NEAR  = 10'd10;
    localparam logic [STEER_W-1:0] ZONE_MID   = 10'd30;
    localparam logic [STEER_W-1:0] ZONE_FAR   = 10'd50;
    localparam logic [SPEED_W-1:0] LIMIT_NEAR = 10'd480;
    localparam logic [SPEED_W-1:0] LIMIT_MID  = 10'd112;
    localparam logic [SPEED_W-1:0] LIMIT_FAR  = 10'd48;
    localparam logic [SPEED_W-1:0] LIMIT_OUT  = 10'd16;

    // Ramp: level candidate is floor(3 * elapsed / 100). From this elapsed time
    // on the candidate is 256 or more, above any 8-bit level.
    localparam logic [TIME_W-1:0] RAMP_SAT_ELAPSED = 32'd8534;
    localparam int                RAMP_E_W         = 14;
    localparam int                RAMP_X_W         = 15;
    // floor(x / 100) = (x * 5243) >> 19 for every x below 25602.
    localparam int                RECIP_W          = 13;
    localparam logic [RECIP_W-1:0] RAMP_RECIP      = 13'd5243;
    localparam int                RECIP_SHIFT      = 19;
    localparam int                RAMP_PROD_W      = RAMP_X_W + RECIP_W;

    typedef struct packed {
        logic [STEER_W-1:0] steer_pos;
        logic               ebrake;
        logic [SPEED_W-1:0] speed;
        logic [TIME_W-1:0]  time_ms;
        logic [STICK_W-1:0] stick_y;
    } t_item;

    typedef struct packed {
        logic [STEER_W-1:0] steer_center;
        logic [LEVEL_W-1:0] max_level;
        logic [LEVEL_W-1:0] restart_level;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] drive_level;
        logic [TIME_W-1:0]  ramp_start;
    } t_state;

endpackage

>>> hdl/ztr_step.sv
module ztr_step (
    input  ztr_pkg::t_item                   i_item,
    input  ztr_pkg::t_cfg                    i_cfg,
    input  ztr_pkg::t_state                  i_state,
    output ztr_pkg::t_state                  o_state,
    output logic [ztr_pkg::LEVEL_W-1:0]      o_pot_value
);
    import ztr_pkg::*;

    logic [STEER_W-1:0]     w_offset;
    logic [SPEED_W-1:0]     w_limit;
    logic [TIME_W-1:0]      w_elapsed;
    logic                   w_sat;
    logic [RAMP_E_W-1:0]    w_e;
    logic [RAMP_X_W-1:0]    w_x;
    logic [RAMP_PROD_W-1:0] w_prod;
    logic [LEVEL_W-1:0]     w_cand;
    logic [LEVEL_W-1:0]     w_peak;
    logic [LEVEL_W-1:0]     w_ramped;

    // Distance of the steering reading from center.
    assign w_offset = (i_item.steer_pos >= i_cfg.steer_center)
                    ? (i_item.steer_pos - i_cfg.steer_center)
                    : (i_cfg.steer_center - i_item.steer_pos);

    always_comb begin
        priority if (w_offset < ZONE_NEAR) begin
            w_limit = LIMIT_NEAR;
        end else if (w_offset < ZONE_MID) begin
            w_limit = LIMIT_MID;
        end else if (w_offset < ZONE_FAR) begin
            w_limit = LIMIT_FAR;
        end else begin
            w_limit = LIMIT_OUT;
        end
    end

    // Long elapsed times saturate the candidate, so only a short elapsed time
    // goes through the reciprocal multiply.
    assign w_elapsed = i_item.time_ms - i_state.ramp_start;
    assign w_sat     = (w_elapsed >= RAMP_SAT_ELAPSED);
    assign w_e       = w_elapsed[RAMP_E_W-1:0];
    assign w_x       = {w_e, 1'b0} + {1'b0, w_e};
    assign w_prod    = RAMP_PROD_W'(w_x) * RAMP_PROD_W'(RAMP_RECIP);
    assign w_cand    = w_prod[RECIP_SHIFT +: LEVEL_W];

    assign w_peak   = (w_cand > i_state.drive_level) ? w_cand : i_state.drive_level;
    assign w_ramped = (w_sat || (w_peak > i_cfg.max_level)) ? i_cfg.max_level : w_peak;

    always_comb begin
        o_state     = i_state;
        o_pot_value = '0;
        priority if (i_item.ebrake) begin
            o_state = i_state;
        end else if (i_item.stick_y >= STICK_RELEASE) begin
            o_state.drive_level = i_cfg.restart_level;
            o_state.ramp_start  = i_item.time_ms;
        end else if (i_item.speed < w_limit) begin
            o_state.drive_level = w_ramped;
            o_pot_value         = w_ramped;
        end else begin
            o_state.drive_level = '0;
        end
    end

endmodule

>>> hdl/zoned_throttle_ramp_controller.sv
// Zoned throttle ramp controller.
//
// Each item on the slave stream is one control sample; each item on the master
// stream is the drive level for the digital potentiometer. Exactly one result
// item leaves for every sample taken, in order.
//
// A sample is captured in an input register and, once the result register is
// free, the steering zone, speed check and ramp arithmetic settle in one pass
// of logic into the result register, updating the stored drive level and
// ramp start at the same edge. One sample can be taken every cycle while the
// receiver takes results, bounded only by the single state update per item.
//
// Reset clears both stream stages, restores the configuration registers and
// sets the drive level to 10 and the ramp start to 0. When the receiver holds
// tready low, the result stays put and the input register still takes one
// more sample, after which s_axis_tready drops until the result is taken.
// Configuration writes take effect at once and are meant for an idle block.
module zoned_throttle_ramp_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // stick_y[7:0], time_ms[39:8], speed[49:40], steer_pos[59:50], zeros[63:60]
    input  logic [63:0]                       s_axis_tdata,
    // ebrake[0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pot_value[7:0]
    output logic [ztr_pkg::LEVEL_W-1:0]       m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [ztr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ztr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ztr_pkg::*;

    t_cfg               r_cfg;
    t_state             r_state;
    t_state             w_state_next;
    t_item              r_item;
    t_item              w_item_in;
    logic               r_in_valid;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_pot;
    logic [LEVEL_W-1:0] w_pot_next;
    logic               w_advance;
    logic               w_take;

    // Unpack the stream payload.
    assign w_item_in.stick_y   = s_axis_tdata[7:0];
    assign w_item_in.time_ms   = s_axis_tdata[39:8];
    assign w_item_in.speed     = s_axis_tdata[49:40];
    assign w_item_in.steer_pos = s_axis_tdata[59:50];
    assign w_item_in.ebrake    = s_axis_tuser;

    // The held sample moves on whenever the result register is free or
    // being emptied; the input register is free when it moves on too.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_pot;

    ztr_step u_step (
        .i_item      (r_item),
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .o_state     (w_state_next),
        .o_pot_value (w_pot_next)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steer_center  <= STEER_CENTER_RST;
            r_cfg.max_level     <= MAX_LEVEL_RST;
            r_cfg.restart_level <= RESTART_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STEER_CENTER:  r_cfg.steer_center  <= i_cfg_data;
                REG_MAX_LEVEL:     r_cfg.max_level     <= i_cfg_data[LEVEL_W-1:0];
                REG_RESTART_LEVEL: r_cfg.restart_level <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Stream control and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state.drive_level <= DRIVE_LEVEL_RST;
            r_state.ramp_start  <= '0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= w_state_next;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= w_item_in;
        end
        if (w_advance) begin
            r_pot <= w_pot_next;
        end
    end

    // A braking sample leaves the stored level and ramp start untouched.
    a_brake_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_item.ebrake) |=> (r_state == $past(r_state)))
        else $error("brake sample changed the controller state");

    // A braking sample always produces a zero level.
    a_brake_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_item.ebrake) |=> (r_pot == '0))
        else $error("brake sample produced a nonzero level");

    // A release sample restores the restart level and records the ramp start.
    a_release_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !r_item.ebrake && (r_item.stick_y >= STICK_RELEASE))
        |=> (r_state.drive_level == $past(r_cfg.restart_level)
             && r_state.ramp_start == $past(r_item.time_ms) && r_pot == '0))
        else $error("release sample did not restart the ramp");

    // A sample that cannot move on is neither lost nor overwritten.
    a_hold_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && r_item == $past(r_item)))
        else $error("stalled sample was lost");

endmodule

>>> bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ztr_pkg::*;

    // Half clock period and the run limit in cycles. The limit leaves a wide
    // margin over the slowest correct run.
    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 58;

    // The control law as the block must implement it.
    localparam logic [STICK_W-1:0] STICK_RELEASED = 8'd90;
    localparam logic [STEER_W-1:0] WINDOW_NEAR = 10'd10;
    localparam logic [STEER_W-1:0] WINDOW_MID = 10'd30;
    localparam logic [STEER_W-1:0] WINDOW_FAR = 10'd50;
    localparam logic [SPEED_W-1:0] CAP_NEAR = 10'(30 * 16);
    localparam logic [SPEED_W-1:0] CAP_MID = 10'(7 * 16);
    localparam logic [SPEED_W-1:0] CAP_FAR = 10'(3 * 16);
    localparam logic [SPEED_W-1:0] CAP_OUT = 10'(1 * 16);

    // One control sample as it travels on the slave stream.
    typedef struct {
        logic [STICK_W-1:0] stick_y;
        logic [TIME_W-1:0]  time_ms;
        logic [SPEED_W-1:0] speed;
        logic               ebrake;
        logic [STEER_W-1:0] steer_pos;
    } t_sample;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // stick_y[7:0], time_ms[39:8], speed[49:40], steer_pos[59:50], zeros[63:60]
    logic [63:0]           s_axis_tdata = '0;
    // ebrake[0]
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // pot_value[7:0]
    logic [LEVEL_W-1:0]    m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    zoned_throttle_ramp_controller dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Samples waiting to be sent, and pot levels waiting to come back.
    t_sample            pending_samples[$];
    logic [LEVEL_W-1:0] expected_levels[$];

    // The testbench's own copy of the configuration and the controller state.
    logic [STEER_W-1:0] cfg_center = STEER_CENTER_RST;
    logic [LEVEL_W-1:0] cfg_max = MAX_LEVEL_RST;
    logic [LEVEL_W-1:0] cfg_restart = RESTART_LEVEL_RST;
    logic [LEVEL_W-1:0] model_level = 8'd10;
    logic [TIME_W-1:0]  model_ramp_start = '0;

    int failures = 0;
    int cycles = 0;

    // Millisecond clock used to build plausible time stamps for random samples.
    logic [TIME_W-1:0] sample_clock_ms = '0;

    // Sender burst control.
    int  burst_left = 0;
    int  gap_left = 0;
    int  bursts_started = 0;
    bit  draining = 1'b0;

    // Receiver stall pattern.
    int  rx_cycle = 0;

    // The speed limit, in 1/16 units, that the steering offset from centre allows.
    function automatic logic [SPEED_W-1:0] zone_cap(input logic [STEER_W-1:0] pos,
                                                    input logic [STEER_W-1:0] center);
        logic [STEER_W-1:0] off;
        off = (pos >= center) ? pos - center : center - pos;
        if (off < WINDOW_NEAR)
            return CAP_NEAR;
        if (off < WINDOW_MID)
            return CAP_MID;
        if (off < WINDOW_FAR)
            return CAP_FAR;
        return CAP_OUT;
    endfunction

    // Advances the controller state by one sample and returns the pot level that
    // the block must write for it.
    function automatic logic [LEVEL_W-1:0] next_pot_level(input t_sample s);
        logic [TIME_W-1:0] elapsed;
        logic [33:0]       ramped;
        // The brake wins over everything, a released stick included, and
        // leaves the state alone.
        if (s.ebrake)
            return '0;
        if (s.stick_y >= STICK_RELEASED) begin
            model_level = cfg_restart;
            model_ramp_start = s.time_ms;
            return '0;
        end
        if (s.speed < zone_cap(s.steer_pos, cfg_center)) begin
            // Elapsed time wraps, so a start "in the future" gives a huge value.
            elapsed = s.time_ms - model_ramp_start;
            ramped = (34'(elapsed) * 34'd3) / 34'd100;
            if (ramped < 34'(model_level))
                ramped = 34'(model_level);
            // Only this path clamps; a level above a lowered maximum comes down here.
            if (ramped > 34'(cfg_max))
                ramped = 34'(cfg_max);
            model_level = ramped[LEVEL_W-1:0];
        end else begin
            model_level = '0;
        end
        return model_level;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic queue_sample(input logic [STICK_W-1:0] stick, input logic [TIME_W-1:0] t,
                                input logic [SPEED_W-1:0] speed, input logic brake,
                                input logic [STEER_W-1:0] steer);
        t_sample s;
        s.stick_y = stick;
        s.time_ms = t;
        s.speed = speed;
        s.ebrake = brake;
        s.steer_pos = steer;
        pending_samples.push_back(s);
    endtask

    // Registers are written one per clock; the model copy follows at once since
    // nothing is in flight while this runs.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_STEER_CENTER:  cfg_center = value;
            REG_MAX_LEVEL:     cfg_max = value[LEVEL_W-1:0];
            REG_RESTART_LEVEL: cfg_restart = value[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until every sample has been sent and every level has come back.
    // Checking at the falling edge keeps clear of the activity at the rising one.
    task automatic wait_until_idle();
        while (pending_samples.size() != 0 || expected_levels.size() != 0 || s_axis_tvalid)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Picks a steering reading around the centre, favouring the zone edges.
    function automatic logic [STEER_W-1:0] pick_steer();
        int off;
        int pos;
        case ($urandom_range(0, 7))
            0: off = $urandom_range(0, 9);
            1: off = 9;
            2: off = 10;
            3: off = 29;
            4: off = 30;
            5: off = 49;
            6: off = 50;
            default: off = $urandom_range(11, 300);
        endcase
        pos = $urandom_range(0, 1) ? int'(cfg_center) + off : int'(cfg_center) - off;
        if (pos < 0 || pos > 1023)
            pos = (pos < 0) ? int'(cfg_center) + off : int'(cfg_center) - off;
        if (pos < 0 || pos > 1023)
            pos = $urandom_range(0, 1023);
        return STEER_W'(pos);
    endfunction

    // Random samples: mostly release-then-push sequences with small time steps so
    // the ramp climbs, speeds close to the zone limits, and some brake and noise.
    task automatic add_random_samples(input int count);
        int                 kind;
        logic [STEER_W-1:0] steer;
        logic [SPEED_W-1:0] cap;
        logic [SPEED_W-1:0] speed;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 29))
                0: sample_clock_ms = $urandom;
                1: sample_clock_ms = sample_clock_ms - $urandom_range(1, 2000);
                default: sample_clock_ms = sample_clock_ms + $urandom_range(0, 400);
            endcase
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                queue_sample(STICK_W'($urandom), $urandom, SPEED_W'($urandom), 1'b1,
                             STEER_W'($urandom));
            end else if (kind < 20) begin
                queue_sample(STICK_W'($urandom_range(90, 255)), sample_clock_ms,
                             SPEED_W'($urandom), 1'b0, STEER_W'($urandom));
            end else if (kind < 92) begin
                steer = pick_steer();
                cap = zone_cap(steer, cfg_center);
                case ($urandom_range(0, 3))
                    0: speed = cap - 1'b1;
                    1: speed = cap;
                    2: speed = SPEED_W'($urandom_range(0, cap - 1));
                    default: speed = SPEED_W'($urandom_range(0, 1023));
                endcase
                queue_sample(STICK_W'($urandom_range(0, 89)), sample_clock_ms, speed, 1'b0,
                             steer);
            end else begin
                queue_sample(STICK_W'($urandom), $urandom, SPEED_W'($urandom),
                             1'($urandom), STEER_W'($urandom));
            end
        end
    endtask

    // Driver: presents queued samples in bursts with gaps between them. Every so
    // often it holds back until all outstanding levels have returned.
    always @(posedge i_clk) begin : driver
        t_sample s;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                s.stick_y = s_axis_tdata[7:0];
                s.time_ms = s_axis_tdata[39:8];
                s.speed = s_axis_tdata[49:40];
                s.steer_pos = s_axis_tdata[59:50];
                s.ebrake = s_axis_tuser;
                expected_levels.push_back(next_pot_level(s));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (draining && expected_levels.size() == 0)
                    draining = 1'b0;
                if (burst_left == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                        bursts_started++;
                        if (bursts_started % 16 == 5)
                            draining = 1'b1;
                    end
                end
                if (burst_left > 0 && !draining && pending_samples.size() != 0) begin
                    s = pending_samples.pop_front();
                    s_axis_tdata <= {4'b0, s.steer_pos, s.speed, s.time_ms, s.stick_y};
                    s_axis_tuser <= s.ebrake;
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each returned level against the oldest prediction and
    // drives tready through phases of steady, random, sparse and periodic stalls.
    always @(posedge i_clk) begin : monitor
        logic [LEVEL_W-1:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_levels.size() == 0) begin
                    note_failure($sformatf("pot level %0d arrived with none expected",
                                           m_axis_tdata));
                end else begin
                    want = expected_levels.pop_front();
                    if (m_axis_tdata !== want)
                        note_failure($sformatf("pot_value expected %0d, got %0d",
                                               want, m_axis_tdata));
                end
            end
            case (rx_cycle[9:8])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= (rx_cycle[3:0] < 4'd10);
            endcase
            rx_cycle++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[zoned_throttle_ramp_controller] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int center_set[RANDOM_PHASES];
        int max_set[RANDOM_PHASES];
        int restart_set[RANDOM_PHASES];

        center_set = '{0, 1023, 860, -1, -1, 512, 5};
        max_set = '{0, 255, 160, -1, -1, 1, 255};
        restart_set = '{0, 255, 10, -1, -1, 254, 0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at the reset configuration.
        queue_sample(8'd0, 32'd0, 10'd0, 1'b0, 10'd860);          // ramp from reset state
        queue_sample(8'd0, 32'd1000, 10'd0, 1'b0, 10'd860);       // candidate 30
        queue_sample(8'd255, 32'd5000, 10'd1023, 1'b1, 10'd1023); // brake while released
        queue_sample(8'd0, 32'd8534, 10'd0, 1'b0, 10'd860);       // candidate 256, clamps
        queue_sample(8'd90, 32'd10000, 10'd0, 1'b0, 10'd860);     // release at the threshold
        queue_sample(8'd89, 32'd10100, 10'd479, 1'b0, 10'd869);   // near zone, just under
        queue_sample(8'd0, 32'd10100, 10'd480, 1'b0, 10'd851);    // near zone, at the limit
        queue_sample(8'd0, 32'd10200, 10'd111, 1'b0, 10'd870);    // mid zone edge
        queue_sample(8'd0, 32'd10200, 10'd112, 1'b0, 10'd850);
        queue_sample(8'd0, 32'd10300, 10'd47, 1'b0, 10'd830);     // far zone edge
        queue_sample(8'd0, 32'd10300, 10'd48, 1'b0, 10'd890);
        queue_sample(8'd0, 32'd10400, 10'd15, 1'b0, 10'd810);     // outer zone edge
        queue_sample(8'd0, 32'd10400, 10'd16, 1'b0, 10'd910);
        queue_sample(8'd0, 32'hFFFF_FFFF, 10'd1023, 1'b0, 10'd0); // extremes, too fast
        queue_sample(8'd95, 32'hFFFF_FF00, 10'd0, 1'b0, 10'd860); // time wraps after this
        queue_sample(8'd0, 32'h0000_0010, 10'd0, 1'b0, 10'd860);
        queue_sample(8'd200, 32'd1000, 10'd0, 1'b0, 10'd860);     // ramp start in the future
        queue_sample(8'd0, 32'd500, 10'd0, 1'b0, 10'd860);
        queue_sample(8'd255, 32'hFFFF_FFFF, 10'd1023, 1'b1, 10'd1023);
        wait_until_idle();

        // A level above a lowered maximum: reach 255, then drop the maximum.
        write_reg(REG_MAX_LEVEL, 10'd255);
        write_reg(REG_RESTART_LEVEL, 10'd255);
        end_writes();
        queue_sample(8'd100, 32'd100, 10'd0, 1'b0, 10'd860);
        queue_sample(8'd0, 32'd200, 10'd0, 1'b0, 10'd860);
        wait_until_idle();
        write_reg(REG_MAX_LEVEL, 10'd50);
        end_writes();
        queue_sample(8'd0, 32'd300, 10'd0, 1'b0, 10'd860);        // clamps down to 50
        queue_sample(8'd120, 32'd400, 10'd0, 1'b0, 10'd860);      // release sets 255, no clamp
        queue_sample(8'd0, 32'd420, 10'd0, 1'b1, 10'd860);        // brake, state kept
        queue_sample(8'd0, 32'd450, 10'd0, 1'b0, 10'd860);        // clamps again
        wait_until_idle();

        // Random phases, each under its own configuration.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_reg(REG_STEER_CENTER,
                      CFG_DATA_W'((center_set[ph] < 0) ? $urandom_range(0, 1023)
                                                       : center_set[ph]));
            write_reg(REG_MAX_LEVEL,
                      CFG_DATA_W'((max_set[ph] < 0) ? $urandom_range(0, 255) : max_set[ph]));
            write_reg(REG_RESTART_LEVEL,
                      CFG_DATA_W'((restart_set[ph] < 0) ? $urandom_range(0, 255)
                                                        : restart_set[ph]));
            end_writes();
            add_random_samples(ITEMS_PER_PHASE);
            wait_until_idle();
        end

        repeat (10) @(negedge i_clk);
        if (expected_levels.size() != 0)
            note_failure($sformatf("%0d pot levels never arrived", expected_levels.size()));
        if (failures == 0)
            $display("[zoned_throttle_ramp_controller] OK");
        else
            $display("[zoned_throttle_ramp_controller] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ztr_pkg.sv
hdl/ztr_step.sv
hdl/zoned_throttle_ramp_controller.sv
bench/testbench.sv
